/* src/gray_sobel_edge_stream_top_macros.svh */
// Assertion helpers shared by the edge stream RTL.
`ifndef GRAY_SOBEL_EDGE_STREAM_TOP_MACROS_SVH
`define GRAY_SOBEL_EDGE_STREAM_TOP_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define GSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define GSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/gse_pkg.sv */
package gse_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 13;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [COL_W-1:0] WIDTH_LAST_RESET  = COL_W'(639);
  localparam logic [ROW_W-1:0] HEIGHT_LAST_RESET = ROW_W'(479);

  // 3x3 neighborhood around the window center; the center itself is unused.
  typedef struct packed {
    logic [7:0] prev_left;
    logic [7:0] cur_left;
    logic [7:0] next_left;
    logic [7:0] prev_mid;
    logic [7:0] next_mid;
    logic [7:0] prev_right;
    logic [7:0] cur_right;
    logic [7:0] next_right;
  } nbhd_t;

  function automatic logic [7:0] to_gray(input logic [7:0] b, input logic [7:0] g,
                                         input logic [7:0] r);
    logic [15:0] acc;
    acc = 16'(b * 16'd29) + 16'(g * 16'd150) + 16'(r * 16'd77);
    return acc[15:8];
  endfunction

  // Clamp a width to [3, MAX_WIDTH] and return the index of the last column.
  function automatic logic [COL_W-1:0] width_last(input logic [WIDTH_W-1:0] v);
    logic [WIDTH_W-1:0] c;
    if (v < WIDTH_W'(3)) c = WIDTH_W'(3);
    else if (v > WIDTH_W'(MAX_WIDTH)) c = WIDTH_W'(MAX_WIDTH);
    else c = v;
    return COL_W'(c - WIDTH_W'(1));
  endfunction

  function automatic logic [ROW_W-1:0] height_last(input logic [HEIGHT_W-1:0] v);
    logic [HEIGHT_W-1:0] c;
    if (v < HEIGHT_W'(3)) c = HEIGHT_W'(3);
    else if (v > HEIGHT_W'(MAX_HEIGHT)) c = HEIGHT_W'(MAX_HEIGHT);
    else c = v;
    return ROW_W'(c - HEIGHT_W'(1));
  endfunction

endpackage

/* src/gse_sobel.sv */
module gse_sobel (
  input  gse_pkg::nbhd_t win,
  output logic [7:0]     magnitude
);
  import gse_pkg::*;

  logic signed [11:0] gx;
  logic signed [11:0] gy;
  logic        [11:0] ax;
  logic        [11:0] ay;
  logic        [11:0] sum;

  always_comb begin
    gx = ($signed({4'd0, win.prev_right}) - $signed({4'd0, win.prev_left}))
       + (($signed({4'd0, win.cur_right}) - $signed({4'd0, win.cur_left})) <<< 1)
       + ($signed({4'd0, win.next_right}) - $signed({4'd0, win.next_left}));
    gy = ($signed({4'd0, win.next_left}) + $signed({3'd0, win.next_mid, 1'b0})
          + $signed({4'd0, win.next_right}))
       - ($signed({4'd0, win.prev_left}) + $signed({3'd0, win.prev_mid, 1'b0})
          + $signed({4'd0, win.prev_right}));
    ax  = gx[11] ? 12'(-gx) : 12'(gx);
    ay  = gy[11] ? 12'(-gy) : 12'(gy);
    sum = ax + ay;
    magnitude = (sum > 12'd255) ? 8'd255 : sum[7:0];
  end

endmodule

/* src/gray_sobel_edge_stream_top.sv */
// Streaming 3x3 Sobel edge magnitude over a BGR raster.
//
// Input stream s_*: one pixel per transfer in raster order, tdata = blue,
// green, red from bit 0 up. The pixel is turned to gray on the way in.
// Output stream m_*: one transfer per interior pixel with |gx| + |gy|
// saturated to 255 and the center's row and column; tlast marks the frame's
// last interior pixel. Border pixels produce no transfer.
// Config port cfg_*: index 0 is frame width, 1 is frame height; any write to
// a known index restarts the frame. Write only while the stream is idle.
//
// Throughput is one pixel per clock while the receiver keeps up. The line
// memory is read at the input transfer into the same stage as the pixel,
// and the Sobel kernel sits between that stage and the output register, so
// a result passes stage A and then the output register before m_tvalid rises.
// A stalled receiver holds the output register; the input keeps accepting as
// long as the stage behind it can move, so bubbles fill before s_tready drops.
// Reset clears counters, window and valid flags and loads a 640x480 frame;
// the line memory is not cleared and needs no clearing pass.
`include "gray_sobel_edge_stream_top_macros.svh"

module gray_sobel_edge_stream_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [gse_pkg::IN_DATA_W-1:0]    s_tdata,   // blue[7:0], green[15:8], red[23:16]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [gse_pkg::OUT_DATA_W-1:0]   m_tdata,   // magnitude[7:0], out_row[19:8],
                                                      // out_col[30:20], zero[31]
  output logic                             m_tlast,   // frame_done
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gse_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gse_pkg::*;

  // Frame geometry, stored as last column / last row after clamping.
  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;

  // Raster position of the next pixel to be accepted.
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;

  // Line memory: bits [15:8] hold row r-2, bits [7:0] row r-1.
  logic [15:0] line_mem [MAX_WIDTH];
  logic [15:0] line_rd;

  // Stage A: accepted pixel together with its line memory data.
  logic             a_valid;
  logic [7:0]       a_gray;
  logic [COL_W-1:0] a_col;
  logic [ROW_W-1:0] a_row;
  logic             a_emit;
  logic             a_done;

  // Window columns: top/mid/bottom of the two columns to the left.
  logic [7:0] win_cols [6];

  // Output register.
  logic             o_valid;
  logic [7:0]       o_mag;
  logic [ROW_W-1:0] o_row;
  logic [COL_W-1:0] o_col;
  logic             o_done;

  logic   s_fire;
  logic   a_adv;
  logic   cfg_hit;
  logic   cfg_fire;
  nbhd_t  win;
  logic [7:0] mag;
  logic [7:0] top_px;
  logic [7:0] mid_px;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_fire && ((cfg_index == REG_FRAME_WIDTH) ||
                                  (cfg_index == REG_FRAME_HEIGHT));

  // Stage A moves when the output register is empty or being drained.
  assign a_adv    = !o_valid || m_tready;
  assign s_tready = !a_valid || a_adv;
  assign s_fire   = s_tvalid && s_tready;

  assign top_px = line_rd[15:8];
  assign mid_px = line_rd[7:0];

  always_comb begin
    win.prev_left  = win_cols[0];
    win.cur_left   = win_cols[1];
    win.next_left  = win_cols[2];
    win.prev_mid   = win_cols[3];
    win.next_mid   = win_cols[5];
    win.prev_right = top_px;
    win.cur_right  = mid_px;
    win.next_right = a_gray;
  end

  gse_sobel u_sobel (
    .win       (win),
    .magnitude (mag)
  );

  // Geometry registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= WIDTH_LAST_RESET;
      h_last <= HEIGHT_LAST_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  w_last <= width_last(cfg_data[WIDTH_W-1:0]);
        REG_FRAME_HEIGHT: h_last <= height_last(cfg_data[HEIGHT_W-1:0]);
        default: ;
      endcase
    end
  end

  // Raster counters: advance on each input transfer, restart on config.
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col_count <= '0;
      row_count <= '0;
    end else if (s_fire) begin
      if (col_count == w_last) begin
        col_count <= '0;
        row_count <= (row_count == h_last) ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  // Line memory: read at accept, write back when stage A moves on.
  always_ff @(posedge clk) begin
    if (s_fire) begin
      line_rd <= line_mem[col_count];
    end
    if (a_valid && a_adv) begin
      line_mem[a_col] <= {mid_px, a_gray};
    end
  end

  // Stage A register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      a_gray <= to_gray(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
      a_col  <= col_count;
      a_row  <= row_count;
      a_emit <= (row_count >= ROW_W'(2)) && (col_count >= COL_W'(2));
      a_done <= (row_count == h_last) && (col_count == w_last);
    end
  end

  // Window shift: drop the oldest column, take the one just read.
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      for (int i = 0; i < 6; i++) begin
        win_cols[i] <= '0;
      end
    end else if (a_valid && a_adv) begin
      win_cols[0] <= win_cols[3];
      win_cols[1] <= win_cols[4];
      win_cols[2] <= win_cols[5];
      win_cols[3] <= top_px;
      win_cols[4] <= mid_px;
      win_cols[5] <= a_gray;
    end
  end

  // Output register: load only interior pixels.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (a_adv) begin
      o_valid <= a_valid && a_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && a_valid && a_emit) begin
      o_mag  <= mag;
      o_row  <= a_row - 1'b1;
      o_col  <= a_col - 1'b1;
      o_done <= a_done;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {1'b0, o_col, o_row, o_mag};
  assign m_tlast  = o_done;

  `GSE_ASSERT(col_in_frame, col_count <= w_last, "column counter past last column")
  `GSE_ASSERT(col_wraps, (s_fire && col_count == w_last) |=> (col_count == '0),
              "column counter did not wrap at row end")
  `GSE_ASSERT(out_interior, m_tvalid |-> ((o_row != '0) && (o_col != '0)),
              "result on a border pixel")
  `GSE_ASSERT_ALWAYS(out_idle_after_reset, $past(rst) |-> !m_tvalid,
                     "result valid right after reset")

endmodule
